>>> design/cia_pkg.sv
// Shared types, codes and helpers for the integer ALU with condition codes.
// No dependencies; used by the channel interfaces, the ALU and its checker.
`timescale 1ns / 1ps

package cia_pkg;

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_ADDX = 4'd2,
    ACT_SUBX = 4'd3,
    ACT_CMP  = 4'd4,
    ACT_NEG  = 4'd5,
    ACT_NEGX = 4'd6,
    ACT_AND  = 4'd7,
    ACT_OR   = 4'd8,
    ACT_EOR  = 4'd9,
    ACT_NOT  = 4'd10,
    ACT_ADDA = 4'd11,
    ACT_SUBA = 4'd12,
    ACT_CMPA = 4'd13
  } action_t;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;

  localparam int FLAG_X = 4;
  localparam int FLAG_N = 3;
  localparam int FLAG_Z = 2;
  localparam int FLAG_V = 1;
  localparam int FLAG_C = 0;

  localparam int DATA_W = 32;
  localparam int CCR_W  = 5;

  // Flag behavior class of an operation
  typedef enum logic [2:0] {
    CLS_ARITH,  // add, sub, neg: all flags, X = C
    CLS_EXT,    // addx, subx, negx: Z only cleared
    CLS_CMP,    // cmp, cmpa: no store, X kept
    CLS_LOGIC,  // and, or, eor, not
    CLS_ADDR,   // adda, suba: 32-bit, flags kept
    CLS_NOP
  } cls_t;

  typedef enum logic [1:0] {
    LOP_AND,
    LOP_OR,
    LOP_EOR,
    LOP_NOT
  } lop_t;

  typedef struct packed {
    cls_t       cls;
    lop_t       lop;
    logic       sub;
    logic       cin;
    logic [1:0] esz;  // effective operand size
  } ctl_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sz);
    logic [DATA_W-1:0] m;
    case (sz)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_WORD: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic msb_bit(input logic [DATA_W-1:0] v, input logic [1:0] sz);
    logic b;
    case (sz)
      SZ_BYTE: b = v[7];
      SZ_WORD: b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

endpackage

>>> design/cia_in_if.sv
// Input channel of the ALU: one operation per transfer.
// Depends on cia_pkg for field widths.
`timescale 1ns / 1ps

interface cia_in_if
  import cia_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [3:0]           action;
  logic [1:0]           size;
  logic [DATA_W-1:0]    source_operand;
  logic [DATA_W-1:0]    dest_operand;
  logic [CCR_W-1:0]     ccr_in;

  modport source (output valid, action, size, source_operand, dest_operand, ccr_in,
                  input ready);
  modport sink   (input valid, action, size, source_operand, dest_operand, ccr_in,
                  output ready);
endinterface

>>> design/cia_out_if.sv
// Result channel of the ALU: stored value, new condition codes, store flag.
// Depends on cia_pkg for field widths.
`timescale 1ns / 1ps

interface cia_out_if
  import cia_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    result_value;
  logic [CCR_W-1:0]     ccr_out;
  logic                 write_back;

  modport source (output valid, result_value, ccr_out, write_back, input ready);
  modport sink   (input valid, result_value, ccr_out, write_back, output ready);
endinterface

>>> design/cisc_integer_alu_with_ccr.sv
// Integer ALU with X/N/Z/V/C condition codes, three register stages.
// Depends on cia_pkg, cia_in_if and cia_out_if.
//
// Accepts one operation per clock while the output is not stalled, and each operation moves
// through the stages in order to the output register. Stage one decodes the operation and
// masks the operands to the operand size, stage two holds the 32-bit adder and the
// logic unit and derives N/V/C at the sized sign bit, stage three does the zero test,
// assembles the condition codes and merges the result into the destination's upper
// bits. Each stage carries its own valid bit and advances whenever the stage after it
// is empty or moving, so up to two more input transfers are taken while a result
// waits at the output before the input stalls.
`timescale 1ns / 1ps

module cisc_integer_alu_with_ccr
  import cia_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cia_in_if.sink     in_ch,
  cia_out_if.source  out_ch
);

  // stage 1: decoded operands
  logic              s1_valid_r;
  ctl_t              s1_ctl_r, s1_ctl_nxt;
  logic [DATA_W-1:0] s1_a_r, s1_a_nxt;
  logic [DATA_W-1:0] s1_b_r, s1_b_nxt;
  logic [DATA_W-1:0] s1_dst_r;
  logic [CCR_W-1:0]  s1_ccr_r;

  // stage 2: raw sized result and flags at the sign bit
  logic              s2_valid_r;
  ctl_t              s2_ctl_r;
  logic [DATA_W-1:0] s2_res_r, s2_res_nxt;
  logic              s2_n_r, s2_n_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic              s2_c_r, s2_c_nxt;
  logic [DATA_W-1:0] s2_dst_r;
  logic [CCR_W-1:0]  s2_ccr_r;

  // stage 3: output register
  logic              s3_valid_r;
  logic [DATA_W-1:0] s3_value_r, s3_value_nxt;
  logic [CCR_W-1:0]  s3_ccr_r, s3_ccr_nxt;
  logic              s3_wb_r, s3_wb_nxt;

  logic rdy1, rdy2, rdy3;

  assign rdy3 = !s3_valid_r || out_ch.ready;
  assign rdy2 = !s2_valid_r || rdy3;
  assign rdy1 = !s1_valid_r || rdy2;
  assign in_ch.ready = rdy1;

  // ---------------- decode ----------------
  logic [DATA_W-1:0] src, dst, s32, a_raw, b_raw, dmask;
  logic              x_in;

  always_comb begin
    src  = in_ch.source_operand;
    dst  = in_ch.dest_operand;
    x_in = in_ch.ccr_in[FLAG_X];
    s32  = (in_ch.size == SZ_BYTE || in_ch.size == SZ_WORD) ?
           {{16{src[15]}}, src[15:0]} : src;
    s1_ctl_nxt.cls = CLS_NOP;
    s1_ctl_nxt.lop = LOP_AND;
    s1_ctl_nxt.sub = 1'b0;
    s1_ctl_nxt.cin = 1'b0;
    s1_ctl_nxt.esz = in_ch.size;
    a_raw = dst;
    b_raw = src;
    case (action_t'(in_ch.action))
      ACT_ADD: begin
        s1_ctl_nxt.cls = CLS_ARITH;
      end
      ACT_SUB: begin
        s1_ctl_nxt.cls = CLS_ARITH;
        s1_ctl_nxt.sub = 1'b1;
      end
      ACT_ADDX: begin
        s1_ctl_nxt.cls = CLS_EXT;
        s1_ctl_nxt.cin = x_in;
      end
      ACT_SUBX: begin
        s1_ctl_nxt.cls = CLS_EXT;
        s1_ctl_nxt.sub = 1'b1;
        s1_ctl_nxt.cin = x_in;
      end
      ACT_CMP: begin
        s1_ctl_nxt.cls = CLS_CMP;
        s1_ctl_nxt.sub = 1'b1;
      end
      ACT_NEG: begin
        s1_ctl_nxt.cls = CLS_ARITH;
        s1_ctl_nxt.sub = 1'b1;
        a_raw = '0;
        b_raw = dst;
      end
      ACT_NEGX: begin
        s1_ctl_nxt.cls = CLS_EXT;
        s1_ctl_nxt.sub = 1'b1;
        s1_ctl_nxt.cin = x_in;
        a_raw = '0;
        b_raw = dst;
      end
      ACT_AND: begin
        s1_ctl_nxt.cls = CLS_LOGIC;
        s1_ctl_nxt.lop = LOP_AND;
      end
      ACT_OR: begin
        s1_ctl_nxt.cls = CLS_LOGIC;
        s1_ctl_nxt.lop = LOP_OR;
      end
      ACT_EOR: begin
        s1_ctl_nxt.cls = CLS_LOGIC;
        s1_ctl_nxt.lop = LOP_EOR;
      end
      ACT_NOT: begin
        s1_ctl_nxt.cls = CLS_LOGIC;
        s1_ctl_nxt.lop = LOP_NOT;
      end
      ACT_ADDA: begin
        s1_ctl_nxt.cls = CLS_ADDR;
        s1_ctl_nxt.esz = SZ_LONG;
        b_raw = s32;
      end
      ACT_SUBA: begin
        s1_ctl_nxt.cls = CLS_ADDR;
        s1_ctl_nxt.sub = 1'b1;
        s1_ctl_nxt.esz = SZ_LONG;
        b_raw = s32;
      end
      ACT_CMPA: begin
        s1_ctl_nxt.cls = CLS_CMP;
        s1_ctl_nxt.sub = 1'b1;
        s1_ctl_nxt.esz = SZ_LONG;
        b_raw = s32;
      end
      default: begin
        s1_ctl_nxt.cls = CLS_NOP;
      end
    endcase
    dmask    = size_mask(s1_ctl_nxt.esz);
    s1_a_nxt = a_raw & dmask;
    s1_b_nxt = b_raw & dmask;
  end

  // ---------------- adder / logic ----------------
  logic [DATA_W-1:0] sum, lres, vvec, cvec;

  always_comb begin
    if (s1_ctl_r.sub) begin
      sum = s1_a_r - s1_b_r - {{(DATA_W-1){1'b0}}, s1_ctl_r.cin};
    end else begin
      sum = s1_a_r + s1_b_r + {{(DATA_W-1){1'b0}}, s1_ctl_r.cin};
    end
    case (s1_ctl_r.lop)
      LOP_AND: lres = s1_a_r & s1_b_r;
      LOP_OR:  lres = s1_a_r | s1_b_r;
      LOP_EOR: lres = s1_a_r ^ s1_b_r;
      default: lres = ~s1_a_r;
    endcase
    s2_res_nxt = ((s1_ctl_r.cls == CLS_LOGIC) ? lres : sum) & size_mask(s1_ctl_r.esz);
    if (s1_ctl_r.sub) begin
      vvec = (s1_b_r ^ s1_a_r) & (s2_res_nxt ^ s1_a_r);
      cvec = (s1_b_r & s2_res_nxt) | (~s1_a_r & (s1_b_r | s2_res_nxt));
    end else begin
      vvec = (s1_b_r ^ s2_res_nxt) & (s1_a_r ^ s2_res_nxt);
      cvec = (s1_b_r & s1_a_r) | (~s2_res_nxt & (s1_b_r | s1_a_r));
    end
    s2_n_nxt = msb_bit(s2_res_nxt, s1_ctl_r.esz);
    s2_v_nxt = msb_bit(vvec, s1_ctl_r.esz);
    s2_c_nxt = msb_bit(cvec, s1_ctl_r.esz);
  end

  // ---------------- flags and merge ----------------
  logic              zero;
  logic [DATA_W-1:0] merged, rmask;

  always_comb begin
    zero   = (s2_res_r == '0);
    rmask  = size_mask(s2_ctl_r.esz);
    merged = (s2_dst_r & ~rmask) | s2_res_r;
    s3_value_nxt = s2_dst_r;
    s3_ccr_nxt   = s2_ccr_r;
    s3_wb_nxt    = 1'b0;
    case (s2_ctl_r.cls)
      CLS_ARITH: begin
        s3_value_nxt = merged;
        s3_ccr_nxt   = {s2_c_r, s2_n_r, zero, s2_v_r, s2_c_r};
        s3_wb_nxt    = 1'b1;
      end
      CLS_EXT: begin
        s3_value_nxt = merged;
        s3_ccr_nxt   = {s2_c_r, s2_n_r, zero & s2_ccr_r[FLAG_Z], s2_v_r, s2_c_r};
        s3_wb_nxt    = 1'b1;
      end
      CLS_CMP: begin
        s3_ccr_nxt = {s2_ccr_r[FLAG_X], s2_n_r, zero, s2_v_r, s2_c_r};
      end
      CLS_LOGIC: begin
        s3_value_nxt = merged;
        s3_ccr_nxt   = {s2_ccr_r[FLAG_X], s2_n_r, zero, 1'b0, 1'b0};
        s3_wb_nxt    = 1'b1;
      end
      CLS_ADDR: begin
        s3_value_nxt = s2_res_r;
        s3_wb_nxt    = 1'b1;
      end
      default: begin
        s3_wb_nxt = 1'b0;
      end
    endcase
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_ch.valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ctl_r <= s1_ctl_nxt;
      s1_a_r   <= s1_a_nxt;
      s1_b_r   <= s1_b_nxt;
      s1_dst_r <= in_ch.dest_operand;
      s1_ccr_r <= in_ch.ccr_in;
    end
    if (rdy2) begin
      s2_ctl_r <= s1_ctl_r;
      s2_res_r <= s2_res_nxt;
      s2_n_r   <= s2_n_nxt;
      s2_v_r   <= s2_v_nxt;
      s2_c_r   <= s2_c_nxt;
      s2_dst_r <= s1_dst_r;
      s2_ccr_r <= s1_ccr_r;
    end
    if (rdy3) begin
      s3_value_r <= s3_value_nxt;
      s3_ccr_r   <= s3_ccr_nxt;
      s3_wb_r    <= s3_wb_nxt;
    end
  end

  assign out_ch.valid        = s3_valid_r;
  assign out_ch.result_value = s3_value_r;
  assign out_ch.ccr_out      = s3_ccr_r;
  assign out_ch.write_back   = s3_wb_r;

endmodule

>>> design/cia_checker.sv
// Port-level checks for the ALU and the bind that attaches them.
// Depends on cia_pkg and the top level cisc_integer_alu_with_ccr.
`timescale 1ns / 1ps

module cia_checker
  import cia_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_value,
  input logic [CCR_W-1:0]  out_ccr,
  input logic              out_wb
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_ccr)
      && $stable(out_wb))
    else $error("result changed while stalled");

  // an empty output stage never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // an unstalled transfer always yields a result at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after unstalled transfer");

  // results only follow an earlier transfer: nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind cisc_integer_alu_with_ccr cia_checker u_cia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.result_value),
  .out_ccr   (out_ch.ccr_out),
  .out_wb    (out_ch.write_back)
);
